// File: hdl/max_pool_2x2_argmax_macros.svh
// assertion macros shared by the max pooling block
`ifndef MAX_POOL_2X2_ARGMAX_MACROS_SVH
`define MAX_POOL_2X2_ARGMAX_MACROS_SVH
`ifndef SYNTHESIS
`define MPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/mpa_pkg.sv
// types and constants of the 2x2 max pooling block
package mpa_pkg;

  localparam int PIXEL_BITS    = 16;
  localparam int MAX_SIDE      = 256;
  localparam int ADDR_BITS     = $clog2(MAX_SIDE);
  localparam int SIDE_BITS     = 9;
  localparam int STRIDE_BITS   = 4;
  localparam int POS_BITS      = 8;
  localparam int OFFSET_BITS   = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_SIDE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE     = 2'd1;

  localparam logic [SIDE_BITS-1:0]   SIDE_RESET   = 9'd28;
  localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 4'd2;

  localparam logic [OFFSET_BITS-1:0] PICK_UP_LEFT   = 2'd0;
  localparam logic [OFFSET_BITS-1:0] PICK_UP_RIGHT  = 2'd1;
  localparam logic [OFFSET_BITS-1:0] PICK_LOW_LEFT  = 2'd2;
  localparam logic [OFFSET_BITS-1:0] PICK_LOW_RIGHT = 2'd3;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    logic                     valid;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  // one complete window waiting for its compare
  typedef struct packed {
    pixel_t              ul;
    pixel_t              ur;
    pixel_t              ll;
    pixel_t              lr;
    logic [POS_BITS-1:0] orow;
    logic [POS_BITS-1:0] ocol;
    logic                done;
  } win_t;

endpackage

// File: hdl/mpa_front.sv
// front end: counters, stride grid tracking, line buffer and window capture
`include "max_pool_2x2_argmax_macros.svh"
module mpa_front (
  input  logic             clk,
  input  logic             rst_n,
  input  mpa_pkg::cfg_wr_t cfg_wr,
  input  logic             in_push,
  input  mpa_pkg::pixel_t  in_pixel,
  output logic             in_full,
  output logic             q_push,
  output mpa_pkg::win_t    q_data,
  input  logic             q_full
);

  logic [mpa_pkg::SIDE_BITS-1:0]   side_r;
  logic [mpa_pkg::STRIDE_BITS-1:0] stride_r;
  logic [mpa_pkg::SIDE_BITS-1:0]   eff_side;
  logic [mpa_pkg::STRIDE_BITS-1:0] eff_st;

  logic [mpa_pkg::ADDR_BITS-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic [mpa_pkg::STRIDE_BITS-1:0] col_ph_r, col_ph_nxt, row_ph_r, row_ph_nxt;
  logic [mpa_pkg::POS_BITS-1:0]    col_idx_r, col_idx_nxt, row_idx_r, row_idx_nxt;
  logic                            lcol_ph0_r, lcol_ph0_nxt, ab_ph0_r, ab_ph0_nxt;
  logic [mpa_pkg::POS_BITS-1:0]    lcol_idx_r, lcol_idx_nxt, ab_idx_r, ab_idx_nxt;

  mpa_pkg::pixel_t line_mem [mpa_pkg::MAX_SIDE];
  mpa_pkg::pixel_t top_q_r;

  logic                         s1_valid_r, s1_emit_r, s1_done_r;
  mpa_pkg::pixel_t              s1_px_r, prev_top_r, prev_px_r;
  logic [mpa_pkg::POS_BITS-1:0] s1_orow_r, s1_ocol_r;

  logic accept, s1_stall, s1_leave, cfg_hit, emit, done, col_last, row_last;

  always_comb begin
    eff_side = side_r;
    if (side_r < mpa_pkg::SIDE_BITS'(2)) eff_side = mpa_pkg::SIDE_BITS'(2);
    if (side_r > mpa_pkg::SIDE_BITS'(mpa_pkg::MAX_SIDE))
      eff_side = mpa_pkg::SIDE_BITS'(mpa_pkg::MAX_SIDE);
    eff_st = (stride_r == '0) ? mpa_pkg::STRIDE_BITS'(1) : stride_r;
  end

  assign cfg_hit  = cfg_wr.valid && (cfg_wr.index == mpa_pkg::REG_IMAGE_SIDE ||
                                     cfg_wr.index == mpa_pkg::REG_STRIDE);
  assign s1_stall = s1_valid_r && s1_emit_r && q_full;
  assign s1_leave = s1_valid_r && !s1_stall;
  assign in_full  = s1_stall;
  assign accept   = in_push && !in_full;
  assign q_push   = s1_valid_r && s1_emit_r && !q_full;

  // a window closes when both its top-left row and column sit on the grid
  assign emit = (row_r != '0) && (col_r != '0) && lcol_ph0_r && ab_ph0_r;
  // last window when the next grid point no longer leaves room for a window
  assign done = ({1'b0, row_r} + mpa_pkg::SIDE_BITS'(eff_st) >= eff_side) &&
                ({1'b0, col_r} + mpa_pkg::SIDE_BITS'(eff_st) >= eff_side);
  assign col_last = ({1'b0, col_r} + mpa_pkg::SIDE_BITS'(1)) >= eff_side;
  assign row_last = ({1'b0, row_r} + mpa_pkg::SIDE_BITS'(1)) >= eff_side;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    col_ph_nxt   = col_ph_r;
    col_idx_nxt  = col_idx_r;
    row_ph_nxt   = row_ph_r;
    row_idx_nxt  = row_idx_r;
    lcol_ph0_nxt = lcol_ph0_r;
    lcol_idx_nxt = lcol_idx_r;
    ab_ph0_nxt   = ab_ph0_r;
    ab_idx_nxt   = ab_idx_r;
    if (cfg_hit) begin
      col_nxt     = '0;
      row_nxt     = '0;
      col_ph_nxt  = '0;
      col_idx_nxt = '0;
      row_ph_nxt  = '0;
      row_idx_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt     = '0;
        col_ph_nxt  = '0;
        col_idx_nxt = '0;
        ab_ph0_nxt  = (row_ph_r == '0);
        ab_idx_nxt  = row_idx_r;
        if (row_last) begin
          row_nxt     = '0;
          row_ph_nxt  = '0;
          row_idx_nxt = '0;
        end else begin
          row_nxt = row_r + mpa_pkg::ADDR_BITS'(1);
          if (row_ph_r + mpa_pkg::STRIDE_BITS'(1) == eff_st) begin
            row_ph_nxt  = '0;
            row_idx_nxt = row_idx_r + mpa_pkg::POS_BITS'(1);
          end else begin
            row_ph_nxt = row_ph_r + mpa_pkg::STRIDE_BITS'(1);
          end
        end
      end else begin
        col_nxt      = col_r + mpa_pkg::ADDR_BITS'(1);
        lcol_ph0_nxt = (col_ph_r == '0);
        lcol_idx_nxt = col_idx_r;
        if (col_ph_r + mpa_pkg::STRIDE_BITS'(1) == eff_st) begin
          col_ph_nxt  = '0;
          col_idx_nxt = col_idx_r + mpa_pkg::POS_BITS'(1);
        end else begin
          col_ph_nxt = col_ph_r + mpa_pkg::STRIDE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r     <= mpa_pkg::SIDE_RESET;
      stride_r   <= mpa_pkg::STRIDE_RESET;
      col_r      <= '0;
      row_r      <= '0;
      col_ph_r   <= '0;
      col_idx_r  <= '0;
      row_ph_r   <= '0;
      row_idx_r  <= '0;
      lcol_ph0_r <= 1'b0;
      lcol_idx_r <= '0;
      ab_ph0_r   <= 1'b0;
      ab_idx_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          mpa_pkg::REG_IMAGE_SIDE: side_r <= cfg_wr.data;
          mpa_pkg::REG_STRIDE:     stride_r <= cfg_wr.data[mpa_pkg::STRIDE_BITS-1:0];
          default: ;
        endcase
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      col_ph_r   <= col_ph_nxt;
      col_idx_r  <= col_idx_nxt;
      row_ph_r   <= row_ph_nxt;
      row_idx_r  <= row_idx_nxt;
      lcol_ph0_r <= lcol_ph0_nxt;
      lcol_idx_r <= lcol_idx_nxt;
      ab_ph0_r   <= ab_ph0_nxt;
      ab_idx_r   <= ab_idx_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_leave) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // line buffer: read the pixel above before it is overwritten
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_r] <= in_pixel;
      top_q_r         <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_pixel;
      s1_emit_r <= emit;
      s1_orow_r <= ab_idx_r;
      s1_ocol_r <= lcol_idx_r;
      s1_done_r <= done;
    end
    if (s1_leave) begin
      prev_top_r <= top_q_r;
      prev_px_r  <= s1_px_r;
    end
  end

  always_comb begin
    q_data.ul   = prev_top_r;
    q_data.ur   = top_q_r;
    q_data.ll   = prev_px_r;
    q_data.lr   = s1_px_r;
    q_data.orow = s1_orow_r;
    q_data.ocol = s1_ocol_r;
    q_data.done = s1_done_r;
  end

  `MPA_ASSERT_NXT(a_cfg_restart, clk, rst_n, cfg_hit, col_r == '0 && row_r == '0)
  `MPA_ASSERT_NXT(a_accept_fills, clk, rst_n, accept, s1_valid_r)
  `MPA_ASSERT_NXT(a_stall_holds, clk, rst_n, s1_stall, s1_valid_r && $stable(s1_px_r))

endmodule

// File: hdl/mpa_queue.sv
// short window queue between the front end and the compare stage
`include "max_pool_2x2_argmax_macros.svh"
module mpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  mpa_pkg::win_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mpa_pkg::win_t data_o,
  output logic          empty_o
);

  mpa_pkg::win_t                 entries [mpa_pkg::QUEUE_DEPTH];
  logic [mpa_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [mpa_pkg::QCNT_BITS-1:0] count_r;

  assign full_o  = (count_r == mpa_pkg::QCNT_BITS'(mpa_pkg::QUEUE_DEPTH));
  assign empty_o = (count_r == '0);
  assign data_o  = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == mpa_pkg::QPTR_BITS'(mpa_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + mpa_pkg::QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == mpa_pkg::QPTR_BITS'(mpa_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + mpa_pkg::QPTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + mpa_pkg::QCNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        count_r <= count_r - mpa_pkg::QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entries[wr_ptr_r] <= data_i;
    end
  end

  `MPA_ASSERT_IMP(a_no_overflow, clk, rst_n, push_i, !full_o)
  `MPA_ASSERT_IMP(a_no_underflow, clk, rst_n, pop_i, !empty_o)
  `MPA_ASSERT_NXT(a_count_up, clk, rst_n, push_i && !pop_i,
                  count_r == $past(count_r) + mpa_pkg::QCNT_BITS'(1))

endmodule

// File: hdl/mpa_back.sv
// back end: window maximum with first-wins tie rule into the result register
module mpa_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  mpa_pkg::win_t                   q_data,
  output logic                            q_pop,
  output logic                            out_empty,
  input  logic                            out_pop,
  output mpa_pkg::pixel_t                 out_pooled_value,
  output logic [mpa_pkg::OFFSET_BITS-1:0] out_pick_offset,
  output logic [mpa_pkg::POS_BITS-1:0]    out_row,
  output logic [mpa_pkg::POS_BITS-1:0]    out_col,
  output logic                            out_plane_done
);

  logic                            out_valid_r;
  mpa_pkg::pixel_t                 best_r, best;
  logic [mpa_pkg::OFFSET_BITS-1:0] pick_r, pick;
  logic [mpa_pkg::POS_BITS-1:0]    row_r, col_r;
  logic                            done_r;

  // strict greater-than keeps the earliest maximum
  always_comb begin
    best = q_data.ul;
    pick = mpa_pkg::PICK_UP_LEFT;
    if (q_data.ur > best) begin
      best = q_data.ur;
      pick = mpa_pkg::PICK_UP_RIGHT;
    end
    if (q_data.ll > best) begin
      best = q_data.ll;
      pick = mpa_pkg::PICK_LOW_LEFT;
    end
    if (q_data.lr > best) begin
      best = q_data.lr;
      pick = mpa_pkg::PICK_LOW_RIGHT;
    end
  end

  assign q_pop     = !q_empty && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      best_r <= best;
      pick_r <= pick;
      row_r  <= q_data.orow;
      col_r  <= q_data.ocol;
      done_r <= q_data.done;
    end
  end

  assign out_pooled_value = best_r;
  assign out_pick_offset  = pick_r;
  assign out_row          = row_r;
  assign out_col          = col_r;
  assign out_plane_done   = done_r;

endmodule

// File: hdl/max_pool_2x2_argmax.sv
// top level of the 2x2 max pooling block with argmax
//
// chan | handshake           | fields
// -----+---------------------+---------------------------------------------------------------
// in   | in_push/in_full     | in_pixel
// out  | out_pop/out_empty   | out_pooled_value, out_pick_offset, out_row, out_col, out_plane_done
// cfg  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one pixel per cycle sustained while in_full stays low; a window result reaches the out side
// once the pixel closing it is taken, by way of the queue write and then the compare register.
// the line buffer is a single-port memory read and written once per pixel.
// reset clears counters, queue pointers and the result valid flag; the line buffer is not cleared.
// a stalled out side backs up through the two-entry queue before in_full rises.
module max_pool_2x2_argmax (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  mpa_pkg::pixel_t                   in_pixel,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output mpa_pkg::pixel_t                   out_pooled_value,
  output logic [mpa_pkg::OFFSET_BITS-1:0]   out_pick_offset,
  output logic [mpa_pkg::POS_BITS-1:0]      out_row,
  output logic [mpa_pkg::POS_BITS-1:0]      out_col,
  output logic                              out_plane_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mpa_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  mpa_pkg::cfg_wr_t cfg_wr;
  mpa_pkg::win_t    fq_data, qb_data;
  logic             fq_push, fq_full, qb_pop, qb_empty;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  mpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_push  (in_push),
    .in_pixel (in_pixel),
    .in_full  (in_full),
    .q_push   (fq_push),
    .q_data   (fq_data),
    .q_full   (fq_full)
  );

  mpa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fq_push),
    .data_i  (fq_data),
    .full_o  (fq_full),
    .pop_i   (qb_pop),
    .data_o  (qb_data),
    .empty_o (qb_empty)
  );

  mpa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (qb_empty),
    .q_data           (qb_data),
    .q_pop            (qb_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pooled_value (out_pooled_value),
    .out_pick_offset  (out_pick_offset),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_plane_done   (out_plane_done)
  );

endmodule
